FILE: src/adjacency_matrix_bfs_dfs_core_assert.svh
// Assertion macros used by the checker file of the adjacency matrix core.
`ifndef ADJACENCY_MATRIX_BFS_DFS_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_BFS_DFS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ADJMX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ADJMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/adjmx_pkg.sv
// ----------------------------------------------------------------------------
// adjmx_pkg
// Shared constants, codes and types of the adjacency matrix walk core.
// ----------------------------------------------------------------------------
package adjmx_pkg;

    localparam int MAX_NODES   = 32;
    localparam int STACK_DEPTH = 1024;

    localparam int VX_W  = $clog2(MAX_NODES);        // vertex index
    localparam int IDX_W = 6;                        // request index field
    localparam int CNT_W = 6;                        // vertex_count register
    localparam int SA_W  = $clog2(STACK_DEPTH);      // stack address
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);  // stack pointer

    // request codes
    localparam logic [2:0] REQ_SET   = 3'd0;
    localparam logic [2:0] REQ_CLEAR = 3'd1;
    localparam logic [2:0] REQ_QUERY = 3'd2;
    localparam logic [2:0] REQ_BFS   = 3'd3;
    localparam logic [2:0] REQ_DFS   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_BFS  = 2'd1;
    localparam logic [1:0] KIND_DFS  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // stack control from the sequencer
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctl_t;

    // stack status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } stk_sts_t;

endpackage

FILE: src/adjmx_stack.sv
// ----------------------------------------------------------------------------
// adjmx_stack
// LIFO of vertex indices for the depth-first walk; pushes to a full stack
// are dropped, popped data is registered and valid in the cycle after the pop.
// ----------------------------------------------------------------------------
module adjmx_stack (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  adjmx_pkg::stk_ctl_t       ctl,
    input  logic [adjmx_pkg::VX_W-1:0] push_data,
    output logic [adjmx_pkg::VX_W-1:0] top_data,
    output adjmx_pkg::stk_sts_t       sts
);
    import adjmx_pkg::*;

    logic [VX_W-1:0] mem [STACK_DEPTH];
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [SP_W-1:0] sp_dec;
    logic [VX_W-1:0] top_reg;

    assign sp_dec    = sp_reg - SP_W'(1);
    assign sts.empty = (sp_reg == '0);
    assign sts.full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign top_data  = top_reg;

    // pointer update
    always_comb begin
        sp_next = sp_reg;
        if (ctl.clear) begin
            sp_next = '0;
        end else if (ctl.push && !sts.full) begin
            sp_next = sp_reg + SP_W'(1);
        end else if (ctl.pop && !sts.empty) begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    // storage: one write, one registered read
    always_ff @(posedge aclk) begin
        if (ctl.push && !sts.full && !ctl.clear) begin
            mem[sp_reg[SA_W-1:0]] <= push_data;
        end
        if (ctl.pop) begin
            top_reg <= mem[sp_dec[SA_W-1:0]];
        end
    end

endmodule

FILE: src/adjacency_matrix_bfs_dfs_core.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_bfs_dfs_core
// Directed adjacency bit matrix with set/clear/query requests and
// breadth-first / depth-first walks that stream out discovered vertices.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_tready is low until its last result
// beat is loaded. A walk scans one matrix column per dequeued or popped
// vertex, one row per cycle unless a discovered vertex waits on a stalled
// result beat, with a single edge-bit test unit.
module adjacency_matrix_bfs_dfs_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: vertex_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row_vertex[5:0], col_vertex[11:6], zero pad
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // vertex[4:0], parent[9:5], distance[14:10],
                                   // ok[15], adjacent[16], zero pad
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import adjmx_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_EXEC     = 9'b000000010,
        ST_BFS_POP  = 9'b000000100,
        ST_BFS_SCAN = 9'b000001000,
        ST_DFS_PUSH = 9'b000010000,
        ST_DFS_POP  = 9'b000100000,
        ST_DFS_TOP  = 9'b001000000,
        ST_DFS_SCAN = 9'b010000000,
        ST_END      = 9'b100000000
    } state_t;

    localparam int QP_W = $clog2(MAX_NODES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] n_eff;

    logic [MAX_NODES-1:0] adj_reg [MAX_NODES];
    logic [MAX_NODES-1:0] vis_reg, vis_next;

    logic [2:0]       req_reg;
    logic [IDX_W-1:0] row_reg, col_reg;
    logic [VX_W-1:0]  src_reg;

    // queue entries carry vertex and its distance
    logic [VX_W-1:0] qv_reg [MAX_NODES];
    logic [VX_W-1:0] qd_reg [MAX_NODES];
    logic [QP_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic            q_push;
    logic [VX_W-1:0] q_push_v, q_push_d;

    logic [VX_W-1:0] u_reg, u_next, du_reg, du_next, v_reg, v_next;

    logic            adj_we, adj_wbit;
    logic            row_ok, both_ok, out_free, scan_bit, scan_done;

    stk_ctl_t        stk_ctl;
    stk_sts_t        stk_sts;
    logic [VX_W-1:0] stk_top, stk_din;

    // result register
    logic            out_load;
    logic            m_valid_reg;
    logic [1:0]      o_kind_reg, o_kind;
    logic [VX_W-1:0] o_vx_reg, o_vx, o_par_reg, o_par, o_dist_reg, o_dist;
    logic            o_ok_reg, o_ok, o_adj_reg, o_adj, o_last_reg, o_last;

    assign n_eff     = (vcount_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : vcount_reg;
    assign row_ok    = row_reg < n_eff;
    assign both_ok   = row_ok && (col_reg < n_eff);
    assign out_free  = !m_valid_reg || m_tready;
    assign scan_bit  = adj_reg[v_reg][u_reg];
    assign scan_done = ({1'b0, v_reg} == (n_eff - CNT_W'(1)));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    adjmx_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (stk_ctl),
        .push_data (stk_din),
        .top_data  (stk_top),
        .sts       (stk_sts)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        vis_next   = vis_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        u_next     = u_reg;
        du_next    = du_reg;
        v_next     = v_reg;
        q_push     = 1'b0;
        q_push_v   = v_reg;
        q_push_d   = du_reg + VX_W'(1);
        adj_we     = 1'b0;
        adj_wbit   = 1'b0;
        stk_ctl    = '0;
        stk_din    = v_reg;
        out_load   = 1'b0;
        o_kind     = KIND_EDGE;
        o_vx       = '0;
        o_par      = '0;
        o_dist     = '0;
        o_ok       = 1'b1;
        o_adj      = 1'b0;
        o_last     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((req_reg == REQ_BFS || req_reg == REQ_DFS) && row_ok) begin
                    if (req_reg == REQ_BFS) begin
                        vis_next   = '0;
                        vis_next[row_reg[VX_W-1:0]] = 1'b1;
                        q_push     = 1'b1;
                        q_push_v   = row_reg[VX_W-1:0];
                        q_push_d   = '0;
                        head_next  = '0;
                        tail_next  = QP_W'(1);
                        state_next = ST_BFS_POP;
                    end else begin
                        vis_next    = '0;
                        stk_ctl.clear = 1'b1;
                        state_next  = ST_DFS_PUSH;
                    end
                end else if (out_free) begin
                    out_load   = 1'b1;
                    o_last     = 1'b1;
                    state_next = ST_IDLE;
                    case (req_reg)
                        REQ_SET, REQ_CLEAR: begin
                            o_ok     = both_ok;
                            adj_we   = both_ok;
                            adj_wbit = (req_reg == REQ_SET);
                        end
                        REQ_QUERY: begin
                            o_ok  = both_ok;
                            o_adj = both_ok && adj_reg[row_reg[VX_W-1:0]][col_reg[VX_W-1:0]];
                        end
                        REQ_BFS, REQ_DFS: begin
                            // walk from a vertex out of range
                            o_kind = KIND_END;
                            o_vx   = row_reg[VX_W-1:0];
                            o_ok   = 1'b0;
                        end
                        default: begin
                            o_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_BFS_POP: begin
                if (head_reg < tail_reg) begin
                    u_next     = qv_reg[head_reg[VX_W-1:0]];
                    du_next    = qd_reg[head_reg[VX_W-1:0]];
                    head_next  = head_reg + QP_W'(1);
                    v_next     = '0;
                    state_next = ST_BFS_SCAN;
                end else begin
                    // queue drained: rewind so the next walk starts at entry 0
                    head_next  = '0;
                    tail_next  = '0;
                    state_next = ST_END;
                end
            end
            ST_BFS_SCAN: begin
                if (!(scan_bit && !vis_reg[v_reg] && !out_free)) begin
                    if (scan_bit && !vis_reg[v_reg]) begin
                        vis_next[v_reg] = 1'b1;
                        out_load = 1'b1;
                        o_kind   = KIND_BFS;
                        o_vx     = v_reg;
                        o_par    = u_reg;
                        o_dist   = du_reg + VX_W'(1);
                        if (tail_reg < QP_W'(MAX_NODES)) begin
                            q_push    = 1'b1;
                            tail_next = tail_reg + QP_W'(1);
                        end
                    end
                    if (scan_done) begin
                        state_next = ST_BFS_POP;
                    end else begin
                        v_next = v_reg + VX_W'(1);
                    end
                end
            end
            ST_DFS_PUSH: begin
                stk_ctl.push = 1'b1;
                stk_din      = src_reg;
                state_next   = ST_DFS_POP;
            end
            ST_DFS_POP: begin
                if (stk_sts.empty) begin
                    state_next = ST_END;
                end else begin
                    stk_ctl.pop = 1'b1;
                    state_next  = ST_DFS_TOP;
                end
            end
            ST_DFS_TOP: begin
                if (({1'b0, stk_top} >= n_eff) || vis_reg[stk_top]) begin
                    state_next = ST_DFS_POP;
                end else if (out_free) begin
                    vis_next[stk_top] = 1'b1;
                    out_load   = 1'b1;
                    o_kind     = KIND_DFS;
                    o_vx       = stk_top;
                    u_next     = stk_top;
                    v_next     = '0;
                    state_next = ST_DFS_SCAN;
                end
            end
            ST_DFS_SCAN: begin
                stk_ctl.push = scan_bit;
                if (scan_done) begin
                    state_next = ST_DFS_POP;
                end else begin
                    v_next = v_reg + VX_W'(1);
                end
            end
            ST_END: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_kind     = KIND_END;
                    o_vx       = src_reg;
                    o_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcount_reg  <= CNT_W'(MAX_NODES);
            vis_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            vis_reg   <= vis_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // adjacency matrix, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                adj_reg[i] <= '0;
            end
        end else if (adj_we) begin
            adj_reg[row_reg[VX_W-1:0]][col_reg[VX_W-1:0]] <= adj_wbit;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        u_reg  <= u_next;
        du_reg <= du_next;
        v_reg  <= v_next;
        if (s_tvalid && s_tready) begin
            req_reg <= s_tuser;
            row_reg <= s_tdata[5:0];
            col_reg <= s_tdata[11:6];
            src_reg <= s_tdata[VX_W-1:0];
        end
        if (q_push) begin
            qv_reg[tail_reg[VX_W-1:0]] <= q_push_v;
            qd_reg[tail_reg[VX_W-1:0]] <= q_push_d;
        end
        if (out_load) begin
            o_kind_reg <= o_kind;
            o_vx_reg   <= o_vx;
            o_par_reg  <= o_par;
            o_dist_reg <= o_dist;
            o_ok_reg   <= o_ok;
            o_adj_reg  <= o_adj;
            o_last_reg <= o_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'b0, o_adj_reg, o_ok_reg, o_dist_reg, o_par_reg, o_vx_reg};

endmodule

FILE: src/adjmx_checker.sv
// ----------------------------------------------------------------------------
// adjmx_checker
// Port-level checks of the adjacency matrix core, bound to the top level.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_bfs_dfs_core_assert.svh"

module adjmx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [5:0]  cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import adjmx_pkg::*;

    // idle only once the final beat of a request is loaded
    `ADJMX_ASSERT_NOW(a_idle_after_last, s_tready && m_tvalid, m_tlast, "idle with open run")
    // a request leaves the block busy in the cycle after its acceptance
    `ADJMX_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    // edge replies are single beats
    `ADJMX_ASSERT_NOW(a_edge_single, m_tvalid && m_tuser == KIND_EDGE, m_tlast,
                      "edge reply not last")
    // an adjacent bit only on a good query
    `ADJMX_ASSERT_NOW(a_adj_ok, m_tvalid && m_tdata[16], m_tdata[15] && m_tuser == KIND_EDGE,
                      "adjacent without ok")
    // stalled result beat holds
    `ADJMX_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
                      "result changed under stall")

endmodule

bind adjacency_matrix_bfs_dfs_core adjmx_checker u_adjmx_checker (.*);
